// ===== rtl/arpc_pkg.sv =====
`timescale 1ns / 1ps
// arpc_pkg: shared widths, codes and types of the arp cache resolver
// used by arpc_tables and arp_cache_resolver_unit; no dependencies
package arpc_pkg;

    localparam int MAC_W = 48;
    localparam int IP_W  = 32;
    localparam int OP_W  = 16;
    localparam int KIND_W = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [MAC_W-1:0] MAC_ALL_ONES = 48'hFFFF_FFFF_FFFF;
    localparam logic [IP_W-1:0]  IP_ALL_ONES  = 32'hFFFF_FFFF;

    // arp operation codes
    localparam logic [OP_W-1:0] OP_REQUEST = 16'd1;
    localparam logic [OP_W-1:0] OP_REPLY   = 16'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_RESOLVED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REQUEST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPLY    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROUTER_IP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP_A  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP_B  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP_C  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP_D  = 3'd6;

    // write strobes from the sequencer to the tables
    typedef struct packed {
        logic mac_we;
        logic ip_we;
    } tbl_ctl_t;

endpackage

// ===== rtl/arpc_tables.sv =====
`timescale 1ns / 1ps
// arpc_tables: mac table and ip table with slot pointers, registered reads
// depends on arpc_pkg
module arpc_tables #(
    parameter int MAC_ENTRIES = 8,
    parameter int IP_ENTRIES  = 8,
    parameter int MAC_IW      = 3,
    parameter int IP_IW       = 3
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  arpc_pkg::tbl_ctl_t       ctl,
    input  logic [MAC_IW-1:0]        mac_addr,
    input  logic [IP_IW-1:0]         ip_addr,
    input  logic [arpc_pkg::MAC_W-1:0] mac_wdata,
    input  logic [arpc_pkg::IP_W-1:0]  ip_wdata,
    input  logic [MAC_IW-1:0]        slot_wdata,
    output logic [arpc_pkg::MAC_W-1:0] mac_rdata,
    output logic [arpc_pkg::IP_W-1:0]  ip_rdata,
    output logic [MAC_IW-1:0]        slot_rdata
);
    import arpc_pkg::*;

    logic [MAC_W-1:0]       mac_mem [MAC_ENTRIES];
    logic [IP_W-1:0]        ip_mem [IP_ENTRIES];
    logic [MAC_IW-1:0]      slot_mem [IP_ENTRIES];
    logic [MAC_ENTRIES-1:0] mac_vld_reg;
    logic [IP_ENTRIES-1:0]  ip_vld_reg;
    logic [MAC_W-1:0]       mac_raw_reg;
    logic [IP_W-1:0]        ip_raw_reg;
    logic [MAC_IW-1:0]      slot_raw_reg;
    logic                   mac_rv_reg;
    logic                   ip_rv_reg;

    // memory arrays, written and read at one address each
    always_ff @(posedge clk)
    begin
        if (ctl.mac_we)
        begin
            mac_mem[mac_addr] <= mac_wdata;
        end
        if (ctl.ip_we)
        begin
            ip_mem[ip_addr]   <= ip_wdata;
            slot_mem[ip_addr] <= slot_wdata;
        end
        mac_raw_reg  <= mac_mem[mac_addr];
        ip_raw_reg   <= ip_mem[ip_addr];
        slot_raw_reg <= slot_mem[ip_addr];
    end

    // entry valid bits, cleared at once by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_vld_reg <= '0;
            ip_vld_reg  <= '0;
            mac_rv_reg  <= 1'b0;
            ip_rv_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.mac_we)
            begin
                mac_vld_reg[mac_addr] <= 1'b1;
            end
            if (ctl.ip_we)
            begin
                ip_vld_reg[ip_addr] <= 1'b1;
            end
            mac_rv_reg <= mac_vld_reg[mac_addr];
            ip_rv_reg  <= ip_vld_reg[ip_addr];
        end
    end

    // an entry never written reads as empty
    assign mac_rdata  = mac_rv_reg ? mac_raw_reg : '0;
    assign ip_rdata   = ip_rv_reg ? ip_raw_reg : '0;
    assign slot_rdata = ip_rv_reg ? slot_raw_reg : '0;

endmodule

// ===== rtl/arp_cache_resolver_unit.sv =====
`timescale 1ns / 1ps
// arp_cache_resolver_unit: arp cache, responder and destination resolver
// a learn walks the mac table and then the ip table, a resolve walks the ip
//   table and then reads the mac of the matching slot; each entry is read, then
//   checked by one shared compare unit over the registered table reads
// throughput: one item at a time, start taken when busy is low; done pulses
//   one cycle and the receiver cannot stall; rst_n clears tables and registers
module arp_cache_resolver_unit #(
    parameter int IP_ENTRIES  = 8,
    parameter int MAC_ENTRIES = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            mode,
    input  logic [arpc_pkg::OP_W-1:0]       arp_opcode,
    input  logic [arpc_pkg::MAC_W-1:0]      sender_mac,
    input  logic [arpc_pkg::IP_W-1:0]       sender_ip,
    input  logic [arpc_pkg::IP_W-1:0]       target_ip,
    input  logic                            cfg_we,
    input  logic [arpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arpc_pkg::MAC_W-1:0]      cfg_data,
    output logic                            done,
    output logic [arpc_pkg::KIND_W-1:0]     result_kind,
    output logic [arpc_pkg::MAC_W-1:0]      dest_mac,
    output logic [arpc_pkg::IP_W-1:0]       frame_sender_ip,
    output logic [arpc_pkg::MAC_W-1:0]      frame_target_mac,
    output logic [arpc_pkg::IP_W-1:0]       frame_target_ip
);
    import arpc_pkg::*;

    localparam int MAC_IW = (MAC_ENTRIES > 1) ? $clog2(MAC_ENTRIES) : 1;
    localparam int IP_IW  = (IP_ENTRIES > 1) ? $clog2(IP_ENTRIES) : 1;
    localparam int CNT_W  = (MAC_IW > IP_IW) ? MAC_IW : IP_IW;
    localparam logic [CNT_W-1:0] MAC_LAST = CNT_W'(MAC_ENTRIES - 1);
    localparam logic [CNT_W-1:0] IP_LAST  = CNT_W'(IP_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MREAD,
        S_MCHK,
        S_IREAD,
        S_ICHK,
        S_SREAD,
        S_SCHK,
        S_RESULT
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [MAC_IW-1:0]  slot_reg;
    logic               mode_reg;
    logic [MAC_W-1:0]   smac_reg;
    logic [IP_W-1:0]    key_ip_reg;
    logic               emit_reg;
    logic               done_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [MAC_W-1:0]   dmac_reg;
    logic [IP_W-1:0]    fsip_reg;
    logic [MAC_W-1:0]   ftmac_reg;
    logic [IP_W-1:0]    ftip_reg;

    logic [IP_W-1:0]    router_ip_reg;
    logic [IP_W-1:0]    subnet_mask_reg;
    logic [MAC_W-1:0]   own_mac_reg;
    logic [IP_W-1:0]    local_ip_a_reg;
    logic [IP_W-1:0]    local_ip_b_reg;
    logic [IP_W-1:0]    local_ip_c_reg;
    logic [IP_W-1:0]    local_ip_d_reg;

    tbl_ctl_t           tbl_ctl;
    logic [MAC_IW-1:0]  mac_addr;
    logic [IP_IW-1:0]   ip_addr;
    logic [MAC_W-1:0]   mac_rdata;
    logic [IP_W-1:0]    ip_rdata;
    logic [MAC_IW-1:0]  slot_rdata;

    logic [MAC_W-1:0]   cmp_data;
    logic [MAC_W-1:0]   cmp_key;
    logic               cmp_eq;
    logic               cmp_zero;
    logic               is_local;
    logic               do_learn;
    logic               off_subnet;
    logic [IP_W-1:0]    dst_ip;
    logic               accept;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            router_ip_reg   <= '0;
            subnet_mask_reg <= '0;
            own_mac_reg     <= '0;
            local_ip_a_reg  <= '0;
            local_ip_b_reg  <= '0;
            local_ip_c_reg  <= '0;
            local_ip_d_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROUTER_IP:   router_ip_reg   <= cfg_data[IP_W-1:0];
                REG_SUBNET_MASK: subnet_mask_reg <= cfg_data[IP_W-1:0];
                REG_OWN_MAC:     own_mac_reg     <= cfg_data;
                REG_LOCAL_IP_A:  local_ip_a_reg  <= cfg_data[IP_W-1:0];
                REG_LOCAL_IP_B:  local_ip_b_reg  <= cfg_data[IP_W-1:0];
                REG_LOCAL_IP_C:  local_ip_c_reg  <= cfg_data[IP_W-1:0];
                REG_LOCAL_IP_D:  local_ip_d_reg  <= cfg_data[IP_W-1:0];
                default:         ;
            endcase
        end
    end

    // item decode at accept
    assign accept   = start && (state_reg == S_IDLE);
    assign is_local = (target_ip != '0) &&
                      ((target_ip == local_ip_a_reg) || (target_ip == local_ip_b_reg) ||
                       (target_ip == local_ip_c_reg) || (target_ip == local_ip_d_reg));
    assign do_learn = ((arp_opcode == OP_REQUEST) || (arp_opcode == OP_REPLY)) &&
                      (sender_ip != '0) && (sender_mac != '0);
    assign off_subnet = (target_ip & subnet_mask_reg) != (router_ip_reg & subnet_mask_reg);
    assign dst_ip     = off_subnet ? router_ip_reg : target_ip;

    // shared compare unit over the table read data
    assign cmp_data = (state_reg == S_MCHK) ? mac_rdata : MAC_W'(ip_rdata);
    assign cmp_key  = (state_reg == S_MCHK) ? smac_reg : MAC_W'(key_ip_reg);
    assign cmp_eq   = (cmp_data == cmp_key);
    assign cmp_zero = (cmp_data == '0);

    // table addressing and write strobes
    assign mac_addr = (state_reg == S_SREAD) ? slot_reg : idx_reg[MAC_IW-1:0];
    assign ip_addr  = idx_reg[IP_IW-1:0];
    assign tbl_ctl.mac_we = (state_reg == S_MCHK) && (cmp_eq || cmp_zero);
    assign tbl_ctl.ip_we  = (state_reg == S_ICHK) && !mode_reg && (cmp_eq || cmp_zero);

    arpc_tables #(
        .MAC_ENTRIES (MAC_ENTRIES),
        .IP_ENTRIES  (IP_ENTRIES),
        .MAC_IW      (MAC_IW),
        .IP_IW       (IP_IW)
    ) u_tables (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (tbl_ctl),
        .mac_addr   (mac_addr),
        .ip_addr    (ip_addr),
        .mac_wdata  (smac_reg),
        .ip_wdata   (key_ip_reg),
        .slot_wdata (slot_reg),
        .mac_rdata  (mac_rdata),
        .ip_rdata   (ip_rdata),
        .slot_rdata (slot_rdata)
    );

    // sequencer with registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            slot_reg   <= '0;
            mode_reg   <= 1'b0;
            smac_reg   <= '0;
            key_ip_reg <= '0;
            emit_reg   <= 1'b0;
            done_reg   <= 1'b0;
            kind_reg   <= KIND_RESOLVED;
            dmac_reg   <= '0;
            fsip_reg   <= '0;
            ftmac_reg  <= '0;
            ftip_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg <= mode;
                        smac_reg <= sender_mac;
                        idx_reg  <= '0;
                        if (!mode)
                        begin
                            // arp message: reply fields are known up front
                            key_ip_reg <= sender_ip;
                            emit_reg   <= (arp_opcode == OP_REQUEST) && is_local;
                            kind_reg   <= KIND_REPLY;
                            dmac_reg   <= sender_mac;
                            fsip_reg   <= target_ip;
                            ftmac_reg  <= sender_mac;
                            ftip_reg   <= sender_ip;
                            state_reg  <= do_learn ? S_MREAD : S_RESULT;
                        end
                        else
                        begin
                            // resolve: default is a request frame on a miss
                            key_ip_reg <= dst_ip;
                            emit_reg   <= 1'b1;
                            ftmac_reg  <= '0;
                            if (dst_ip == IP_ALL_ONES)
                            begin
                                kind_reg  <= KIND_RESOLVED;
                                dmac_reg  <= MAC_ALL_ONES;
                                fsip_reg  <= '0;
                                ftip_reg  <= '0;
                                state_reg <= S_RESULT;
                            end
                            else
                            begin
                                kind_reg  <= KIND_REQUEST;
                                dmac_reg  <= '0;
                                fsip_reg  <= sender_ip;
                                ftip_reg  <= dst_ip;
                                state_reg <= (dst_ip == '0) ? S_RESULT : S_IREAD;
                            end
                        end
                    end
                end
                S_MREAD:
                begin
                    state_reg <= S_MCHK;
                end
                S_MCHK:
                begin
                    // mac entry equal or empty takes the learn
                    if (cmp_eq || cmp_zero)
                    begin
                        slot_reg  <= idx_reg[MAC_IW-1:0];
                        idx_reg   <= '0;
                        state_reg <= S_IREAD;
                    end
                    else if (idx_reg == MAC_LAST)
                    begin
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_MREAD;
                    end
                end
                S_IREAD:
                begin
                    state_reg <= S_ICHK;
                end
                S_ICHK:
                begin
                    if (!mode_reg && (cmp_eq || cmp_zero))
                    begin
                        state_reg <= S_RESULT;
                    end
                    else if (mode_reg && cmp_eq)
                    begin
                        // hit: fetch the mac that the entry points at
                        slot_reg  <= slot_rdata;
                        state_reg <= S_SREAD;
                    end
                    else if (idx_reg == IP_LAST)
                    begin
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_IREAD;
                    end
                end
                S_SREAD:
                begin
                    state_reg <= S_SCHK;
                end
                S_SCHK:
                begin
                    kind_reg  <= KIND_RESOLVED;
                    dmac_reg  <= mac_rdata;
                    fsip_reg  <= '0;
                    ftip_reg  <= '0;
                    state_reg <= S_RESULT;
                end
                S_RESULT:
                begin
                    done_reg  <= emit_reg;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign result_kind      = kind_reg;
    assign dest_mac         = dmac_reg;
    assign frame_sender_ip  = fsip_reg;
    assign frame_target_mac = ftmac_reg;
    assign frame_target_ip  = ftip_reg;

`ifndef SYNTHESIS
    // a result only follows the closing step of an item
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_RESULT))
        else $error("result without closing step");

    // an accepted item always occupies the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start");

    // result kind is one of the three defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result_kind == KIND_RESOLVED || result_kind == KIND_REQUEST ||
                  result_kind == KIND_REPLY))
        else $error("bad result kind");

    // table writes happen only during a learn
    assert property (@(posedge clk) disable iff (!rst_n)
        (tbl_ctl.mac_we || tbl_ctl.ip_we) |-> !mode_reg)
        else $error("table write during resolve");
`endif

endmodule

// ===== test/arp_cache_resolver_unit_tb.sv =====
`timescale 1ns / 1ps
// arp_cache_resolver_unit_tb: self-checking bench for the arp cache resolver
// depends on arpc_pkg and arp_cache_resolver_unit; a class keeps the cache
// model and the queue of predicted results, plain tasks drive the ports

import arpc_pkg::*;

localparam int MAC_SLOTS = 8;
localparam int IP_SLOTS  = 8;

typedef struct packed {
    logic              mode;
    logic [OP_W-1:0]   opcode;
    logic [MAC_W-1:0]  smac;
    logic [IP_W-1:0]   sip;
    logic [IP_W-1:0]   tip;
} arp_item_t;

typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [MAC_W-1:0]  dmac;
    logic [IP_W-1:0]   fsip;
    logic [MAC_W-1:0]  ftmac;
    logic [IP_W-1:0]   ftip;
} arp_result_t;

class arp_scoreboard;
    // register copies
    bit [IP_W-1:0]  router_ip;
    bit [IP_W-1:0]  subnet_mask;
    bit [MAC_W-1:0] own_mac;
    bit [IP_W-1:0]  local_ip[4];

    // cache copies, zero marks an empty entry
    bit [MAC_W-1:0] mac_tbl[MAC_SLOTS];
    bit [IP_W-1:0]  ip_tbl[IP_SLOTS];
    bit [2:0]       slot_tbl[IP_SLOTS];

    arp_result_t pending[$];
    int errors;

    function new();
        router_ip = '0;
        subnet_mask = '0;
        own_mac = '0;
        errors = 0;
        foreach (local_ip[k]) local_ip[k] = '0;
        foreach (mac_tbl[k]) mac_tbl[k] = '0;
        foreach (ip_tbl[k]) ip_tbl[k] = '0;
        foreach (slot_tbl[k]) slot_tbl[k] = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MAC_W-1:0] data);
        case (idx)
            REG_ROUTER_IP:   router_ip = data[IP_W-1:0];
            REG_SUBNET_MASK: subnet_mask = data[IP_W-1:0];
            REG_OWN_MAC:     own_mac = data;
            REG_LOCAL_IP_A:  local_ip[0] = data[IP_W-1:0];
            REG_LOCAL_IP_B:  local_ip[1] = data[IP_W-1:0];
            REG_LOCAL_IP_C:  local_ip[2] = data[IP_W-1:0];
            REG_LOCAL_IP_D:  local_ip[3] = data[IP_W-1:0];
            default: ;
        endcase
    endfunction

    // dedupe the mac, then point the ip entry at its slot
    function void learn_pair(bit [IP_W-1:0] ip, bit [MAC_W-1:0] mac);
        int k;
        int m_slot;
        int i_slot;
        if (ip == '0 || mac == '0)
            return;
        m_slot = MAC_SLOTS;
        for (k = 0; k < MAC_SLOTS && m_slot == MAC_SLOTS; k++)
            if (mac_tbl[k] == mac || mac_tbl[k] == '0)
                m_slot = k;
        if (m_slot == MAC_SLOTS)
            return;
        mac_tbl[m_slot] = mac;
        i_slot = IP_SLOTS;
        for (k = 0; k < IP_SLOTS && i_slot == IP_SLOTS; k++)
            if (ip_tbl[k] == ip || ip_tbl[k] == '0)
                i_slot = k;
        if (i_slot == IP_SLOTS)
            return;
        ip_tbl[i_slot] = ip;
        slot_tbl[i_slot] = m_slot[2:0];
    endfunction

    function bit is_local_ip(bit [IP_W-1:0] ip);
        if (ip == '0)
            return 1'b0;
        foreach (local_ip[k])
            if (local_ip[k] == ip)
                return 1'b1;
        return 1'b0;
    endfunction

    // predict the result of an accepted item and update the cache copy
    function void note_item(arp_item_t it);
        arp_result_t r;
        bit [IP_W-1:0] dst;
        bit hit_done;
        int k;
        r = '0;
        hit_done = 1'b0;
        if (!it.mode) begin
            if (it.opcode == OP_REQUEST || it.opcode == OP_REPLY)
                learn_pair(it.sip, it.smac);
            if (it.opcode == OP_REQUEST && is_local_ip(it.tip)) begin
                r.kind = KIND_REPLY;
                r.dmac = it.smac;
                r.fsip = it.tip;
                r.ftmac = it.smac;
                r.ftip = it.sip;
                pending.push_back(r);
            end
            return;
        end
        dst = it.tip;
        if ((dst & subnet_mask) != (router_ip & subnet_mask))
            dst = router_ip;
        if (dst == IP_ALL_ONES) begin
            r.kind = KIND_RESOLVED;
            r.dmac = MAC_ALL_ONES;
            pending.push_back(r);
            return;
        end
        // first equal ip entry decides; a stale slot counts as a miss
        if (dst != '0) begin
            for (k = 0; k < IP_SLOTS && !hit_done; k++) begin
                if (ip_tbl[k] == dst) begin
                    hit_done = 1'b1;
                    if (slot_tbl[k] < MAC_SLOTS) begin
                        r.kind = KIND_RESOLVED;
                        r.dmac = mac_tbl[slot_tbl[k]];
                        pending.push_back(r);
                        return;
                    end
                end
            end
        end
        r.kind = KIND_REQUEST;
        r.fsip = it.sip;
        r.ftip = dst;
        pending.push_back(r);
    endfunction

    function void cmp_field(string name, logic [MAC_W-1:0] want, logic [MAC_W-1:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= 10)
                $display("%0t mismatch %s: expected %h got %h", $time, name, want, got);
        end
    endfunction

    function void check_result(arp_result_t got);
        arp_result_t want;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("%0t result with nothing pending: %h", $time, got);
            return;
        end
        want = pending.pop_front();
        cmp_field("result_kind", MAC_W'(want.kind), MAC_W'(got.kind));
        cmp_field("dest_mac", want.dmac, got.dmac);
        cmp_field("frame_sender_ip", MAC_W'(want.fsip), MAC_W'(got.fsip));
        cmp_field("frame_target_mac", want.ftmac, got.ftmac);
        cmp_field("frame_target_ip", MAC_W'(want.ftip), MAC_W'(got.ftip));
    endfunction
endclass

module arp_cache_resolver_unit_tb;

    localparam int N_ITEMS       = 850;
    localparam int PHASE_ITEMS   = 120;
    localparam int SETTLE_CYCLES = 4 * MAC_SLOTS + 4 * IP_SLOTS + 8;
    localparam int STALL_LIMIT   = 3000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 mode;
    logic [OP_W-1:0]      arp_opcode;
    logic [MAC_W-1:0]     sender_mac;
    logic [IP_W-1:0]      sender_ip;
    logic [IP_W-1:0]      target_ip;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MAC_W-1:0]     cfg_data;
    logic                 done;
    logic [KIND_W-1:0]    result_kind;
    logic [MAC_W-1:0]     dest_mac;
    logic [IP_W-1:0]      frame_sender_ip;
    logic [MAC_W-1:0]     frame_target_mac;
    logic [IP_W-1:0]      frame_target_ip;

    arp_scoreboard sb = new();

    logic [IP_W-1:0]  ip_pool[12];
    logic [MAC_W-1:0] mac_pool[11];
    int idle_pct;
    int stall_cnt;

    arp_cache_resolver_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .mode             (mode),
        .arp_opcode       (arp_opcode),
        .sender_mac       (sender_mac),
        .sender_ip        (sender_ip),
        .target_ip        (target_ip),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .result_kind      (result_kind),
        .dest_mac         (dest_mac),
        .frame_sender_ip  (frame_sender_ip),
        .frame_target_mac (frame_target_mac),
        .frame_target_ip  (frame_target_ip)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result({result_kind, dest_mac, frame_sender_ip,
                             frame_target_mac, frame_target_ip});
    end

    // watchdog on cycles with no item and no result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cnt <= 0;
        else if (stall_cnt >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            stall_cnt <= stall_cnt + 1;
    end

    function automatic logic [MAC_W-1:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[MAC_W-1:0];
    endfunction

    function automatic arp_item_t mk(logic m, logic [OP_W-1:0] op, logic [MAC_W-1:0] smac,
                                     logic [IP_W-1:0] sip, logic [IP_W-1:0] tip);
        arp_item_t it;
        it.mode = m;
        it.opcode = op;
        it.smac = smac;
        it.sip = sip;
        it.tip = tip;
        return it;
    endfunction

    function automatic logic [MAC_W-1:0] pick_mac();
        if ($urandom_range(99) < 5)
            return '0;
        return mac_pool[$urandom_range(10)];
    endfunction

    function automatic logic [IP_W-1:0] pick_ip();
        if ($urandom_range(99) < 5)
            return '0;
        return ip_pool[$urandom_range(11)];
    endfunction

    // mostly well-formed learns and resolves over small address pools, some noise
    function automatic arp_item_t rand_item();
        arp_item_t it;
        int pick;
        it = mk(1'b0, OP_REQUEST, pick_mac(), pick_ip(), pick_ip());
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            if ($urandom_range(1))
                it.tip = sb.local_ip[$urandom_range(3)];
        end
        else if (pick < 60)
            it.opcode = OP_REPLY;
        else if (pick < 90)
        begin
            it.mode = 1'b1;
            it.opcode = OP_W'($urandom);
            it.smac = rand48();
            it.sip = $urandom;
            case ($urandom_range(7))
                0: it.tip = sb.router_ip;
                1: it.tip = IP_ALL_ONES;
                2: it.tip = '0;
                3: it.tip = $urandom;
                default: ;
            endcase
        end
        else
            it = mk(1'($urandom_range(1)), OP_W'($urandom), rand48(), $urandom, $urandom);
        return it;
    endfunction

    // present one item and hold it until the block takes it
    task automatic send_item(input arp_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        mode <= it.mode;
        arp_opcode <= it.opcode;
        sender_mac <= it.smac;
        sender_ip <= it.sip;
        target_ip <= it.tip;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(it);
    endtask

    // drop start, wait for all results, then let a silent item finish
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [MAC_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        sb.write_reg(idx, data);
    endtask

    // fixed extremes first, random settings after
    task automatic apply_setting(input int k);
        logic [IP_W-1:0] loc[4];
        int plen;
        case (k)
            0:
            begin
                write_cfg(REG_ROUTER_IP, 48'hC0A8_0101);
                write_cfg(REG_SUBNET_MASK, 48'hFFFF_FF00);
                write_cfg(REG_OWN_MAC, 48'h0200_0000_0001);
                loc = '{32'hC0A8_010A, 32'hC0A8_010B, 32'hC0A8_010C, 32'hC0A8_010D};
            end
            1:
            begin
                write_cfg(REG_ROUTER_IP, 48'hFFFF_FFFF);
                write_cfg(REG_SUBNET_MASK, 48'h0);
                write_cfg(REG_OWN_MAC, MAC_ALL_ONES);
                loc = '{ip_pool[1], 32'h0, 32'h0, IP_ALL_ONES};
            end
            2:
            begin
                write_cfg(REG_ROUTER_IP, 48'h0);
                write_cfg(REG_SUBNET_MASK, 48'hFFFF_FFFF);
                write_cfg(REG_OWN_MAC, 48'h0);
                loc = '{32'h0, 32'h0, 32'h0, 32'h0};
            end
            default:
            begin
                plen = $urandom_range(32);
                write_cfg(REG_ROUTER_IP,
                          MAC_W'($urandom_range(1) ? ip_pool[$urandom_range(11)]
                                                   : IP_W'($urandom)));
                write_cfg(REG_SUBNET_MASK,
                          MAC_W'(IP_W'((plen == 0) ? 32'h0 : (~32'h0 << (32 - plen)))));
                write_cfg(REG_OWN_MAC, rand48());
                foreach (loc[j])
                    case ($urandom_range(2))
                        0: loc[j] = '0;
                        1: loc[j] = $urandom;
                        default: loc[j] = ip_pool[$urandom_range(11)];
                    endcase
            end
        endcase
        write_cfg(REG_LOCAL_IP_A, MAC_W'(loc[0]));
        write_cfg(REG_LOCAL_IP_B, MAC_W'(loc[1]));
        write_cfg(REG_LOCAL_IP_C, MAC_W'(loc[2]));
        write_cfg(REG_LOCAL_IP_D, MAC_W'(loc[3]));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        arp_item_t it;
        int n_done;
        int next_cfg;
        int phase;

        rst_n = 1'b0;
        start = 1'b0;
        mode = 1'b0;
        arp_opcode = '0;
        sender_mac = '0;
        sender_ip = '0;
        target_ip = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = 23;

        // address pools a bit larger than the tables so both fill up
        ip_pool[0] = 32'hC0A8_0101;
        ip_pool[1] = 32'hC0A8_010A;
        ip_pool[2] = 32'hC0A8_0120;
        for (int j = 3; j < 8; j++)
            ip_pool[j] = {24'hC0A801, 8'($urandom_range(2, 254))};
        ip_pool[8] = IP_ALL_ONES;
        ip_pool[9] = 32'h0A00_0001;
        ip_pool[10] = $urandom;
        ip_pool[11] = $urandom;
        mac_pool[0] = MAC_ALL_ONES;
        for (int j = 1; j < 11; j++)
            mac_pool[j] = rand48() | 48'h1;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // registers at reset value: zero mask keeps every destination
        send_item(mk(1'b1, 16'h0, 48'h0, 32'hC0A8_0105, 32'h0));
        send_item(mk(1'b1, 16'h0, 48'h0, 32'hC0A8_0105, IP_ALL_ONES));
        // zero target never matches an unused local address
        send_item(mk(1'b0, OP_REQUEST, mac_pool[1], ip_pool[9], 32'h0));
        send_item(mk(1'b1, 16'h0, 48'h0, 32'h0, ip_pool[9]));
        settle();
        apply_setting(0);

        // miss inside the subnet, then off-subnet through the router
        send_item(mk(1'b1, 16'h0, 48'h0, 32'hC0A8_0105, ip_pool[2]));
        send_item(mk(1'b1, 16'h0, 48'h0, 32'hC0A8_0105, 32'h0808_0808));
        send_item(mk(1'b0, OP_REPLY, mac_pool[2], ip_pool[0], 32'hC0A8_0105));
        send_item(mk(1'b1, 16'h0, 48'h0, 32'hC0A8_0105, 32'h0808_0808));
        // request for a local address is answered and learned
        send_item(mk(1'b0, OP_REQUEST, mac_pool[3], ip_pool[2], 32'hC0A8_010A));
        // zero sender ip or mac: answered, not learned
        send_item(mk(1'b0, OP_REQUEST, mac_pool[4], 32'h0, 32'hC0A8_010D));
        send_item(mk(1'b0, OP_REQUEST, 48'h0, 32'hC0A8_0121, 32'hC0A8_010B));
        send_item(mk(1'b1, 16'h0, 48'h0, 32'hC0A8_0105, 32'hC0A8_0121));
        // other opcodes leave the cache alone
        send_item(mk(1'b0, 16'h0, mac_pool[5], ip_pool[3], 32'hC0A8_010A));
        send_item(mk(1'b0, 16'h3, mac_pool[5], ip_pool[3], 32'hC0A8_010A));
        send_item(mk(1'b0, 16'hFFFF, mac_pool[5], ip_pool[3], 32'hC0A8_010A));
        send_item(mk(1'b1, 16'h0, 48'h0, 32'hC0A8_0105, ip_pool[3]));
        // all-ones sender and ignored fields in resolve mode
        send_item(mk(1'b0, OP_REQUEST, MAC_ALL_ONES, IP_ALL_ONES, 32'hC0A8_010C));
        send_item(mk(1'b1, 16'hFFFF, MAC_ALL_ONES, IP_ALL_ONES, ip_pool[2]));
        // relearn an ip with a known mac moves its slot
        send_item(mk(1'b0, OP_REPLY, mac_pool[2], ip_pool[2], 32'h0));
        send_item(mk(1'b1, 16'h0, 48'h0, 32'h0, ip_pool[2]));

        // random part in phases with fresh register settings
        n_done = 0;
        next_cfg = PHASE_ITEMS;
        phase = 1;
        while (n_done < N_ITEMS)
        begin
            if (n_done >= next_cfg)
            begin
                settle();
                apply_setting(phase);
                phase++;
                next_cfg += PHASE_ITEMS;
            end
            if (n_done < N_ITEMS / 3)
                idle_pct = 23;
            else if (n_done < 2 * N_ITEMS / 3)
                idle_pct = 79;
            else
                idle_pct = 0;
            it = rand_item();
            send_item(it);
            n_done++;
        end
        settle();

        if (sb.pending.size() != 0)
        begin
            sb.errors++;
            $display("%0d predicted results never arrived", sb.pending.size());
        end
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/arpc_pkg.sv
rtl/arpc_tables.sv
rtl/arp_cache_resolver_unit.sv
test/arp_cache_resolver_unit_tb.sv
